// ===== design/tccc_pkg.sv =====
// tccc_pkg: shared constants and types for the ts continuity counter checker
// no dependencies; imported by the front, queue, back and top modules
`timescale 1ns / 1ps
`default_nettype none

package tccc_pkg;

  // header field widths
  localparam int PID_W = 13;
  localparam int CC_W  = 4;

  // number of pids tracked; pids at or above this are ignored
  localparam int PID_COUNT = 8192;
  localparam int PID_AW    = $clog2(PID_COUNT);

  // null pid, never tracked
  localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;

  // per-pid state word: {seen, last_count}
  localparam int ST_W = CC_W + 1;

  // item queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // bus widths; the data buses are padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic               discontinuity;
    logic               has_payload;
    logic [CC_W-1:0]    continuity_counter;
    logic [PID_W-1:0]   pid;
  } tccc_item_t;

  typedef struct packed {
    logic [CC_W-1:0]    actual_count;
    logic [CC_W-1:0]    expected_count;
    logic [PID_W-1:0]   error_pid;
  } tccc_result_t;

endpackage

`default_nettype wire

// ===== design/tccc_ram.sv =====
// tccc_ram: generic single-write, single-read memory with registered read
// self-contained; used for the per-pid state table
`timescale 1ns / 1ps
`default_nettype none

module tccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/tccc_fifo.sv =====
// tccc_fifo: short item queue between the front and back parts
// depends on tccc_pkg for the item type and depth
`timescale 1ns / 1ps
`default_nettype none

module tccc_fifo
  import tccc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire tccc_item_t push_item,
  input  wire logic       pop,
  output tccc_item_t      head,
  output logic            empty,
  output logic            full
);

  tccc_item_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/tccc_front.sv =====
// tccc_front: input side, accepts header items and drops untracked pids
// depends on tccc_pkg; feeds tccc_fifo
`timescale 1ns / 1ps
`default_nettype none

module tccc_front
  import tccc_pkg::*;
(
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  table_ready,
  input  wire logic                  q_full,
  output logic                       q_push,
  output tccc_item_t                 q_item
);

  localparam logic [PID_W:0] PID_LIMIT = (PID_W+1)'(PID_COUNT);

  logic pid_ok;

  always_comb begin
    q_item.pid                = in_tdata[PID_W-1:0];
    q_item.continuity_counter = in_tdata[PID_W +: CC_W];
    q_item.has_payload        = in_tuser[0];
    q_item.discontinuity      = in_tuser[1];
  end

  // null pid and pids beyond the table never reach the back
  assign pid_ok = (q_item.pid != NULL_PID) && ({1'b0, q_item.pid} < PID_LIMIT);

  assign in_tready = table_ready && !q_full;
  assign q_push    = in_tvalid && in_tready && pid_ok;

endmodule

`default_nettype wire

// ===== design/tccc_back.sv =====
// tccc_back: clears the pid table, then does read-check-write per item
// depends on tccc_pkg; drives tccc_ram and holds the result register
`timescale 1ns / 1ps
`default_nettype none

module tccc_back
  import tccc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire tccc_item_t   q_head,
  output logic              q_pop,
  output logic              table_ready,
  output logic              ram_wr_en,
  output logic [PID_AW-1:0] ram_wr_addr,
  output logic [ST_W-1:0]   ram_wr_data,
  output logic              ram_rd_en,
  output logic [PID_AW-1:0] ram_rd_addr,
  input  wire logic [ST_W-1:0] ram_rd_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tccc_result_t      out_result
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [PID_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  tccc_item_t        cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  tccc_result_t      out_result_r, out_result_nxt;

  logic              seen;
  logic [CC_W-1:0]   last_cc;
  logic [CC_W-1:0]   expected;
  logic              mismatch;
  logic              out_free;

  assign seen     = ram_rd_data[CC_W];
  assign last_cc  = ram_rd_data[CC_W-1:0];
  assign expected = cur_r.has_payload ? last_cc + 1'b1 : last_cc;
  assign mismatch = seen && !cur_r.discontinuity &&
                    (cur_r.continuity_counter != expected);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    q_pop          = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = cur_r.pid[PID_AW-1:0];
    ram_wr_data    = {1'b1, cur_r.continuity_counter};
    ram_rd_en      = 1'b0;
    ram_rd_addr    = q_head.pid[PID_AW-1:0];

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == PID_AW'(PID_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_rd_en = 1'b1;
          cur_nxt   = q_head;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // hold here while an error result cannot be placed; read data stays put
        if (!mismatch || out_free) begin
          ram_wr_en = 1'b1;
          state_nxt = ST_IDLE;
          if (mismatch) begin
            out_valid_nxt                 = 1'b1;
            out_result_nxt.error_pid      = cur_r.pid;
            out_result_nxt.expected_count = expected;
            out_result_nxt.actual_count   = cur_r.continuity_counter;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_result_r <= out_result_nxt;
  end

  assign table_ready = (state_r != ST_CLEAR);
  assign out_valid   = out_valid_r;
  assign out_result  = out_result_r;

endmodule

`default_nettype wire

// ===== design/ts_continuity_counter_check_top.sv =====
// ts_continuity_counter_check_top: top level of the ts continuity counter checker
// depends on tccc_pkg, tccc_front, tccc_fifo, tccc_back and tccc_ram
`timescale 1ns / 1ps
`default_nettype none

// Checks the continuity counter of transport-stream packet headers per pid. Each
// input item carries one header; an output item is produced only when the counter
// breaks continuity (expected last+1 with payload, last unchanged without). The
// first packet of a pid and packets with the discontinuity flag just store the
// counter; the null pid is ignored. After reset the block sweeps its pid table,
// one entry per cycle, so in_tready stays low until the sweep is done. Then the
// back end takes a tracked item as a state table read, then a check and write
// back, split by the table's registered read; null-pid items are dropped at the
// input. A four-item queue lets the input keep accepting while the back end works
// or waits on a stalled output.
module ts_continuity_counter_check_top
  import tccc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input header items
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,   // pid[12:0], continuity_counter[16:13], zero pad
  input  wire logic [IN_USER_W-1:0]   in_tuser,   // has_payload[0], discontinuity[1]
  // continuity error items
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata   // error_pid[12:0], expected_count[16:13],
                                                  // actual_count[20:17], zero pad
);

  // front to queue
  logic         q_push;
  tccc_item_t   q_item;
  // queue to back
  logic         q_pop;
  logic         q_empty;
  logic         q_full;
  tccc_item_t   q_head;
  // table sweep done
  logic         table_ready;
  // pid state table port
  logic              ram_wr_en;
  logic [PID_AW-1:0] ram_wr_addr;
  logic [ST_W-1:0]   ram_wr_data;
  logic              ram_rd_en;
  logic [PID_AW-1:0] ram_rd_addr;
  logic [ST_W-1:0]   ram_rd_data;
  // result register
  tccc_result_t out_result;

  tccc_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .table_ready (table_ready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  tccc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tccc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .table_ready (table_ready),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (out_result)
  );

  // per-pid {seen, last counter}; cleared by the sweep after reset
  tccc_ram #(
    .WIDTH (ST_W),
    .DEPTH (PID_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // pack result fields, lowest first, zero fill to the byte
  assign out_tdata = {(OUT_DATA_W - $bits(tccc_result_t))'(0), out_result};

endmodule

`default_nettype wire

// ===== tb/ts_continuity_counter_check_checker.sv =====
// ts_continuity_counter_check_checker: scoreboard for the ts continuity counter checker
// watches both stream channels, predicts continuity errors per pid and compares them
// depends on tccc_pkg
`timescale 1ns / 1ps

module ts_continuity_counter_check_checker
  import tccc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  output int                         mismatch_count,
  output int                         results_owed
);

  // shadow of the per-pid table
  logic            pid_seen_tbl [PID_COUNT];
  logic [CC_W-1:0] last_cc_tbl  [PID_COUNT];

  // continuity errors predicted but not yet seen on the output
  tccc_result_t cc_error_q [$];
  int           mismatches = 0;

  function automatic void track_header(input logic [PID_W-1:0] pid,
                                       input logic [CC_W-1:0]  cc,
                                       input logic             pay,
                                       input logic             disc);
    logic [CC_W-1:0] want;
    tccc_result_t    err;
    if (pid == NULL_PID || int'(pid) >= PID_COUNT) return;
    if (!pid_seen_tbl[pid] || disc) begin
      pid_seen_tbl[pid] = 1'b1;
      last_cc_tbl[pid]  = cc;
      return;
    end
    want = pay ? last_cc_tbl[pid] + 1'b1 : last_cc_tbl[pid];
    last_cc_tbl[pid] = cc;
    if (cc != want) begin
      err.error_pid      = pid;
      err.expected_count = want;
      err.actual_count   = cc;
      cc_error_q.push_back(err);
    end
  endfunction

  function automatic void note_mismatch(input string what, input tccc_result_t exp_item,
                                        input tccc_result_t got_item);
    if (mismatches < 10)
      $display({"%0t mismatch (%s): exp pid=%0d exp_cc=%0d act_cc=%0d,",
                " got pid=%0d exp_cc=%0d act_cc=%0d"},
               $realtime, what, exp_item.error_pid, exp_item.expected_count,
               exp_item.actual_count, got_item.error_pid, got_item.expected_count,
               got_item.actual_count);
    mismatches++;
  endfunction

  function automatic void check_error_item(input logic [OUT_DATA_W-1:0] data);
    tccc_result_t got_item;
    tccc_result_t exp_item;
    got_item = data[$bits(tccc_result_t)-1:0];
    if (cc_error_q.size() == 0) begin
      exp_item = '0;
      note_mismatch("unexpected item", exp_item, got_item);
      return;
    end
    exp_item = cc_error_q.pop_front();
    if (got_item.error_pid != exp_item.error_pid ||
        got_item.expected_count != exp_item.expected_count ||
        got_item.actual_count != exp_item.actual_count)
      note_mismatch("field", exp_item, got_item);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PID_COUNT; i++) pid_seen_tbl[i] = 1'b0;
      cc_error_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        track_header(in_tdata[PID_W-1:0], in_tdata[PID_W+CC_W-1:PID_W],
                     in_tuser[0], in_tuser[1]);
      if (out_tvalid && out_tready)
        check_error_item(out_tdata);
    end
    mismatch_count <= mismatches;
    results_owed   <= cc_error_q.size();
  end

endmodule

// ===== tb/ts_continuity_counter_check_top_tb.sv =====
// ts_continuity_counter_check_top_tb: stimulus and verdict for the ts continuity counter checker
// drives header items with random gaps and output stalls; checking lives in the checker module
// depends on tccc_pkg, ts_continuity_counter_check_top and ts_continuity_counter_check_checker
`timescale 1ns / 1ps

module ts_continuity_counter_check_top_tb;
  import tccc_pkg::*;

  localparam int RANDOM_ITEMS = 1400;  // non-null headers in the random part
  localparam int PHASE_ITEMS  = 100;   // idling modes are redrawn every phase
  localparam int LANES        = 8;     // pids carried as well-formed streams
  localparam int SETTLE       = 20;    // cycles after the last result, covers back end + queue
  localparam int RUN_LIMIT    = 250000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatch_count;
  int                    results_owed;

  // idling controls: no_gap keeps the sender back to back, no_stall keeps out_tready high
  logic tx_no_gap   = 1'b0;
  logic rx_no_stall = 1'b0;
  int   rx_hold     = 0;
  int   rx_draw;
  int   cycle_count = 0;

  // stream lanes: pid and the last counter sent on it
  logic [PID_W-1:0] lane_pid [LANES];
  logic [CC_W-1:0]  lane_cc  [LANES];

  ts_continuity_counter_check_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ts_continuity_counter_check_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, reckoned from the table sweep plus worst-case gaps and stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: after each accepted item draw a random stall on out_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tvalid && out_tready) begin
      rx_draw = rx_no_stall ? 0 : $urandom_range(0, 12);
      rx_hold    <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one header item; in_tvalid stays high across back-to-back items
  task automatic send_header(input logic [PID_W-1:0] pid, input logic [CC_W-1:0] cc,
                             input logic pay, input logic disc);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-PID_W-CC_W){1'b0}}, cc, pid};
    in_tuser  <= {disc, pay};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off the sender until every predicted error item has come out
  task automatic drain_errors();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_lane_pid();
    return $urandom_range(0, 1) ? PID_W'($urandom_range(0, 8190))
                                : PID_W'($urandom_range(0, 31));
  endfunction

  initial begin
    int               kind;
    int               k;
    int               count;
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    logic             pay;
    logic             disc;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pid 0 back to back so a table read right after a write to the same entry is hit
    tx_no_gap = 1'b1;
    send_header(13'd0, 4'd0, 1'b1, 1'b0);      // first sighting
    send_header(13'd0, 4'd1, 1'b1, 1'b0);      // in order with payload
    send_header(13'd0, 4'd1, 1'b0, 1'b0);      // no payload, counter held
    send_header(13'd0, 4'd3, 1'b1, 1'b0);      // skipped counter
    send_header(13'd0, 4'd4, 1'b0, 1'b0);      // moved without payload
    send_header(13'd0, 4'd9, 1'b1, 1'b1);      // discontinuity, any counter taken
    send_header(13'd0, 4'd10, 1'b1, 1'b0);
    tx_no_gap = 1'b0;
    send_header(13'd8190, 4'd15, 1'b0, 1'b0);  // highest tracked pid, first sighting
    send_header(13'd8190, 4'd0, 1'b1, 1'b0);   // wrap 15 -> 0
    send_header(13'd8190, 4'd15, 1'b1, 1'b0);  // error, expected 1
    send_header(NULL_PID, 4'd15, 1'b1, 1'b1);  // null pid ignored
    send_header(NULL_PID, 4'd0, 1'b0, 1'b0);
    send_header(13'd8190, 4'd0, 1'b1, 1'b0);   // wrap again
    send_header(13'h1555, 4'd5, 1'b1, 1'b1);   // first sighting with discontinuity
    send_header(13'h0AAA, 4'd10, 1'b0, 1'b0);
    send_header(13'h0AAA, 4'd10, 1'b1, 1'b0);  // payload but counter held
    send_header(13'h1555, 4'd5, 1'b0, 1'b1);
    send_header(13'h1555, 4'd5, 1'b0, 1'b0);
    send_header(13'd0, 4'd0, 1'b1, 1'b0);      // error on pid 0, expected 11
    drain_errors();

    for (int i = 0; i < LANES; i++) begin
      lane_pid[i] = pick_lane_pid();
      lane_cc[i]  = 4'($urandom_range(0, 15));
    end

    // random: mostly well-formed streams, some broken counters, discontinuities and noise
    for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
      tx_no_gap = ($urandom_range(0, 3) == 0);
      rx_no_stall <= ($urandom_range(0, 3) == 0);
      lane_pid[$urandom_range(0, LANES - 1)] = pick_lane_pid();
      count = 0;
      while (count < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, LANES - 1);
        pid  = lane_pid[k];
        pay  = ($urandom_range(0, 7) != 0);
        disc = 1'b0;
        cc   = pay ? lane_cc[k] + 1'b1 : lane_cc[k];
        if (kind >= 75 && kind < 83) begin
          // broken counter on a stream
          cc = 4'($urandom_range(0, 15));
        end else if (kind >= 83 && kind < 88) begin
          disc = 1'b1;
          cc   = 4'($urandom_range(0, 15));
        end else if (kind >= 88 && kind < 93) begin
          pid = NULL_PID;
          cc  = 4'($urandom_range(0, 15));
          disc = 1'($urandom_range(0, 1));
        end else if (kind >= 93) begin
          // noise anywhere in the pid space
          pid  = PID_W'($urandom_range(0, 8191));
          cc   = 4'($urandom_range(0, 15));
          pay  = 1'($urandom_range(0, 1));
          disc = ($urandom_range(0, 3) == 0);
        end
        if (kind < 88) lane_cc[k] = cc;
        send_header(pid, cc, pay, disc);
        if (pid != NULL_PID) count++;
      end
      if (phase == 6) drain_errors();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
